// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL files; bmp_rle4_pixel_decoder.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define BMP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside of reset.
`define BMP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- hdl/bmprle_pkg.sv -----
package bmprle_pkg;

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_ENC_VALUE,
      PH_ESCAPE,
      PH_DX,
      PH_DY,
      PH_LITERAL,
      PH_PAD,
      PH_FINISHED
   } phase_type;

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_STRIDE   = 2'd2;

   localparam logic [7:0] ESC_END_OF_LINE  = 8'h00;
   localparam logic [7:0] ESC_END_OF_IMAGE = 8'h01;
   localparam logic [7:0] ESC_DELTA        = 8'h02;

   localparam logic KIND_RUN  = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [3:0] NIBBLE_MASK = 4'hf;

endpackage

// ----- hdl/bmprle_clip.sv -----
module bmprle_clip import bmprle_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic [7:0]            want,
   input  logic [COORD_BITS-1:0] column,
   input  logic [31:0]           write_offset,
   input  logic [15:0]           image_width,
   input  logic [31:0]           buffer_end,
   output logic [7:0]            run_length
);

   localparam int WIDE = (COORD_BITS > 16) ? COORD_BITS : 16;
   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   logic [WIDE-1:0] width_ext;
   logic [WIDE-1:0] cmax_ext;
   logic [WIDE-1:0] limit;
   logic [WIDE-1:0] column_ext;
   logic [WIDE-1:0] col_room;
   logic [31:0]     buf_room;
   logic [7:0]      col_room8;
   logic [7:0]      buf_room8;
   logic [7:0]      first_min;

   assign width_ext  = WIDE'(image_width);
   assign cmax_ext   = WIDE'(COORD_MAX);
   assign limit      = (width_ext < cmax_ext) ? width_ext : cmax_ext;
   assign column_ext = WIDE'(column);
   assign col_room   = limit - column_ext;
   assign buf_room   = buffer_end - write_offset;

   // Both room figures are capped at a byte, since a run is never longer.
   assign col_room8 = (|col_room[WIDE-1:8]) ? 8'hff : col_room[7:0];
   assign buf_room8 = (|buf_room[31:8]) ? 8'hff : buf_room[7:0];
   assign first_min = (col_room8 < want) ? col_room8 : want;

   always_comb begin
      if (column_ext >= limit || write_offset >= buffer_end) begin
         run_length = 8'd0;
      end else if (buf_room8 < first_min) begin
         run_length = buf_room8;
      end else begin
         run_length = first_min;
      end
   end

endmodule

// ----- hdl/bmprle_offset.sv -----
module bmprle_offset import bmprle_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic [COORD_BITS-1:0] row,
   input  logic [COORD_BITS-1:0] column,
   input  logic [15:0]           row_stride,
   output logic [31:0]           write_offset
);

   localparam int PW = COORD_BITS + 16;
   localparam int SW = (PW + 1 > 33) ? PW + 1 : 33;

   logic [PW-1:0] product;
   logic [SW-1:0] sum;

   assign product = PW'(row) * PW'(row_stride);
   assign sum     = SW'(product) + SW'(column);

   // Offsets that do not fit in 32 bits pin at all ones, past any buffer end.
   assign write_offset = (|sum[SW-1:32]) ? 32'hffff_ffff : sum[31:0];

endmodule

// ----- hdl/bmp_rle4_pixel_decoder.sv -----
// Decoder for 4-bit run-length compressed bitmap data.
// The req channel takes one stream byte per request in req_tdata; req_tuser set
// clears position and parse state before that byte is decoded. The rsp channel
// gives at most one result per request: a pixel run (rsp_tuser low) with its
// buffer offset, length and the two alternating nibble values, or an image
// finished marker (rsp_tuser high) with all data bits zero.
// The csr port writes image_width, image_height and row_stride; the buffer
// end product is registered from the stored values in the cycle after a write.
// A request taken into the input register is decoded into the rsp register.
// Throughput is one request per cycle while the receiver takes results; each
// request passes through one input register and combinational decode
// logic, whose longest path is the row times stride multiply of a line end
// or a move. Reset clears the position, the parse state and both registers,
// and sets all three csr values to 1. When the receiver stalls, the result
// holds in the rsp register, one more request is taken into the input
// register, and the decoder then waits until the result is taken.
module bmp_rle4_pixel_decoder import bmprle_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_image
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] pixel_offset, [39:32] run_length,
                                    // [43:40] first_value, [47:44] second_value
   output logic        rsp_tuser,   // [0] result_kind
   input  logic        csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0] csr_wdata
);

`include "assert_macros.svh"

   localparam int WIDE = (COORD_BITS > 16) ? COORD_BITS : 16;
   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic [15:0] stride_ff;
   logic [31:0] buffer_end_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_sof_ff;

   phase_type             phase_ff,  phase_in;
   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] row_ff,    row_in;
   logic [31:0]           offset_ff, offset_in;
   logic [7:0]            held_ff,   held_in;
   logic [7:0]            lit_ff,    lit_in;
   logic [7:0]            dx_ff,     dx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff,  rsp_kind_in;
   logic [31:0] rsp_off_ff,   rsp_off_in;
   logic [7:0]  rsp_len_ff,   rsp_len_in;
   logic [3:0]  rsp_v1_ff,    rsp_v1_in;
   logic [3:0]  rsp_v2_ff,    rsp_v2_in;

   logic out_free;
   logic fire;

   phase_type             eff_phase;
   logic [COORD_BITS-1:0] eff_column;
   logic [COORD_BITS-1:0] eff_row;
   logic [31:0]           eff_offset;
   logic [7:0]            eff_held;
   logic [7:0]            eff_lit;
   logic [7:0]            eff_dx;

   logic [7:0]            clip_want;
   logic [7:0]            clip_len;
   logic [COORD_BITS:0]   row_sum;
   logic [COORD_BITS:0]   col_sum;
   logic [COORD_BITS-1:0] mv_row;
   logic [COORD_BITS-1:0] mv_column;
   logic [31:0]           mv_offset;
   logic                  past_rows;
   logic                  mv_past_rows;
   logic [7:0]            lit_take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {rsp_v2_ff, rsp_v1_ff, rsp_len_ff, rsp_off_ff};

   // Start of image acts on the state before the byte itself is decoded.
   assign eff_phase  = s1_sof_ff ? PH_COUNT : phase_ff;
   assign eff_column = s1_sof_ff ? '0 : column_ff;
   assign eff_row    = s1_sof_ff ? '0 : row_ff;
   assign eff_offset = s1_sof_ff ? 32'd0 : offset_ff;
   assign eff_held   = s1_sof_ff ? 8'd0 : held_ff;
   assign eff_lit    = s1_sof_ff ? 8'd0 : lit_ff;
   assign eff_dx     = s1_sof_ff ? 8'd0 : dx_ff;

   assign clip_want = (eff_phase == PH_ESCAPE) ? s1_byte_ff : eff_held;

   bmprle_clip #(
      .COORD_BITS(COORD_BITS)
   ) u_clip (
      .want         (clip_want),
      .column       (eff_column),
      .write_offset (eff_offset),
      .image_width  (width_ff),
      .buffer_end   (buffer_end_ff),
      .run_length   (clip_len)
   );

   // A line end steps one row down to column zero; a move adds dx and dy.
   always_comb begin
      if (eff_phase == PH_DY) begin
         row_sum = {1'b0, eff_row} + (COORD_BITS + 1)'(s1_byte_ff);
         col_sum = {1'b0, eff_column} + (COORD_BITS + 1)'(eff_dx);
      end else begin
         row_sum = {1'b0, eff_row} + (COORD_BITS + 1)'(1);
         col_sum = '0;
      end
   end

   assign mv_row    = row_sum[COORD_BITS] ? COORD_MAX : row_sum[COORD_BITS-1:0];
   assign mv_column = col_sum[COORD_BITS] ? COORD_MAX : col_sum[COORD_BITS-1:0];

   bmprle_offset #(
      .COORD_BITS(COORD_BITS)
   ) u_offset (
      .row          (mv_row),
      .column       (mv_column),
      .row_stride   (stride_ff),
      .write_offset (mv_offset)
   );

   assign past_rows    = WIDE'(eff_row) >= WIDE'(height_ff);
   assign mv_past_rows = WIDE'(mv_row) >= WIDE'(height_ff);
   assign lit_take     = (eff_lit >= 8'd2) ? 8'd2 : eff_lit;

   always_comb begin
      phase_in    = phase_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      offset_in   = offset_ff;
      held_in     = held_ff;
      lit_in      = lit_ff;
      dx_in       = dx_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in = KIND_RUN;
      rsp_off_in  = eff_offset;
      rsp_len_in  = 8'd0;
      rsp_v1_in   = 4'd0;
      rsp_v2_in   = 4'd0;
      if (fire) begin
         phase_in  = eff_phase;
         column_in = eff_column;
         row_in    = eff_row;
         offset_in = eff_offset;
         held_in   = eff_held;
         lit_in    = eff_lit;
         dx_in     = eff_dx;
         if (eff_phase != PH_FINISHED && !past_rows) begin
            case (eff_phase)
               PH_COUNT: begin
                  if (s1_byte_ff != 8'd0) begin
                     held_in  = s1_byte_ff;
                     phase_in = PH_ENC_VALUE;
                  end else begin
                     phase_in = PH_ESCAPE;
                  end
               end
               PH_ENC_VALUE: begin
                  phase_in = PH_COUNT;
                  if (clip_len != 8'd0) begin
                     rsp_valid_in = 1'b1;
                     rsp_len_in   = clip_len;
                     rsp_v1_in    = s1_byte_ff[7:4];
                     rsp_v2_in    = s1_byte_ff[3:0] & NIBBLE_MASK;
                     column_in    = eff_column + COORD_BITS'(clip_len);
                     offset_in    = eff_offset + 32'(clip_len);
                  end
               end
               PH_ESCAPE: begin
                  if (s1_byte_ff == ESC_END_OF_LINE) begin
                     column_in = mv_column;
                     row_in    = mv_row;
                     offset_in = mv_offset;
                     if (mv_past_rows) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_DONE;
                        rsp_off_in   = 32'd0;
                        phase_in     = PH_FINISHED;
                     end else begin
                        phase_in = PH_COUNT;
                     end
                  end else if (s1_byte_ff == ESC_END_OF_IMAGE) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_DONE;
                     rsp_off_in   = 32'd0;
                     phase_in     = PH_FINISHED;
                  end else if (s1_byte_ff == ESC_DELTA) begin
                     phase_in = PH_DX;
                  end else begin
                     held_in = s1_byte_ff;
                     lit_in  = clip_len;
                     if (clip_len != 8'd0) begin
                        phase_in = PH_LITERAL;
                     end else if (s1_byte_ff[1:0] == 2'd1 || s1_byte_ff[1:0] == 2'd2) begin
                        phase_in = PH_PAD;
                     end else begin
                        phase_in = PH_COUNT;
                     end
                  end
               end
               PH_DX: begin
                  dx_in    = s1_byte_ff;
                  phase_in = PH_DY;
               end
               PH_DY: begin
                  column_in = mv_column;
                  row_in    = mv_row;
                  offset_in = mv_offset;
                  if (mv_past_rows) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_DONE;
                     rsp_off_in   = 32'd0;
                     phase_in     = PH_FINISHED;
                  end else begin
                     phase_in = PH_COUNT;
                  end
               end
               PH_LITERAL: begin
                  lit_in       = eff_lit - lit_take;
                  rsp_valid_in = 1'b1;
                  rsp_len_in   = lit_take;
                  rsp_v1_in    = s1_byte_ff[7:4];
                  rsp_v2_in    = (lit_take == 8'd2) ? (s1_byte_ff[3:0] & NIBBLE_MASK) : 4'd0;
                  column_in    = eff_column + COORD_BITS'(lit_take);
                  offset_in    = eff_offset + 32'(lit_take);
                  if (eff_lit == lit_take) begin
                     // The run is padded to an even byte count in the stream.
                     if (eff_held[1:0] == 2'd1 || eff_held[1:0] == 2'd2) begin
                        phase_in = PH_PAD;
                     end else begin
                        phase_in = PH_COUNT;
                     end
                  end
               end
               PH_PAD: begin
                  phase_in = PH_COUNT;
               end
               default: begin
                  phase_in = PH_FINISHED;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 16'd1;
         height_ff     <= 16'd1;
         stride_ff     <= 16'd1;
         buffer_end_ff <= 32'd1;
         s1_valid_ff   <= 1'b0;
         phase_ff      <= PH_COUNT;
         column_ff     <= '0;
         row_ff        <= '0;
         offset_ff     <= 32'd0;
         held_ff       <= 8'd0;
         lit_ff        <= 8'd0;
         dx_ff         <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
               CSR_ROW_STRIDE:   stride_ff <= csr_wdata;
               default: ;
            endcase
         end
         buffer_end_ff <= {16'd0, stride_ff} * {16'd0, height_ff};
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         phase_ff  <= phase_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         offset_ff <= offset_in;
         held_ff   <= held_in;
         lit_ff    <= lit_in;
         dx_ff     <= dx_in;
         if (out_free) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_sof_ff  <= req_tuser;
      end
      if (out_free) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_off_ff  <= rsp_off_in;
         rsp_len_ff  <= rsp_len_in;
         rsp_v1_ff   <= rsp_v1_in;
         rsp_v2_ff   <= rsp_v2_in;
      end
   end

   `BMP_ASSERT(a_done_is_empty, clock, reset, (rsp_valid_ff && rsp_kind_ff == KIND_DONE) |-> (rsp_tdata == 48'd0), "finished result carries nonzero data")
   `BMP_ASSERT_NEVER(a_run_not_empty, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_RUN && rsp_len_ff == 8'd0, "pixel run result of zero length")
   `BMP_ASSERT(a_finished_sticks, clock, reset, (phase_ff == PH_FINISHED && !(fire && s1_sof_ff)) |=> (phase_ff == PH_FINISHED), "decoder left the finished state without a start of image")
   `BMP_ASSERT(a_literal_count, clock, reset, (lit_ff != 8'd0) |-> (phase_ff == PH_LITERAL), "literal pixels pending outside of an absolute run")

endmodule
